// ===== design/ufp_pkg.sv =====
// Types and constants shared by the UART buffer pair with RTS/CTS flow control.
`timescale 1ns / 1ps
`default_nettype none

package ufp_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned THR_W       = 8;
  localparam int unsigned RX_LEVEL_W  = 8;
  localparam int unsigned TX_LEVEL_W  = 7;
  localparam int unsigned FAULT_W     = 2;
  localparam int unsigned S_TDATA_W   = 16;
  localparam int unsigned S_TUSER_W   = OP_W;
  localparam int unsigned M_FIELDS_W  = 2 * BYTE_W + 2 + RX_LEVEL_W + TX_LEVEL_W + FAULT_W;
  localparam int unsigned M_TDATA_W   = 40;
  localparam int unsigned M_TDATA_PAD = M_TDATA_W - M_FIELDS_W;
  localparam int unsigned M_TUSER_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LINK_RX    = 3'd0,
    OP_HOST_READ  = 3'd1,
    OP_HOST_WRITE = 3'd2,
    OP_LINE_READY = 3'd3,
    OP_CTS_CHANGE = 3'd4
  } opcode_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE        = 2'd0,
    FAULT_RX_OVERFLOW = 2'd1,
    FAULT_RX_EMPTY    = 2'd2,
    FAULT_TX_FULL     = 2'd3
  } fault_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ufp_cmd_t;

endpackage

`default_nettype wire

// ===== design/uart_fifo_pair_rts_cts.sv =====
// Top level: UART receive/transmit buffer pair with RTS/CTS flow control.
// Each input transaction is one event (link byte, host read, host write, line ready or CTS
// change) and produces exactly one result transaction. An event is handled first in the
// cycle it is accepted, in which the buffer memories present their registered read data,
// and then in an update cycle; no new event is taken before it ends, as s_tready drops
// for the update cycle, and longer only while the result register is still held by a
// stalled m_tready. RTS (active low) reads back as deasserted once the receive level reaches
// the threshold written on cfg_wdata (reset RX_DEPTH - 2). Overflow, empty reads and full
// writes are dropped and reported in the fault field.
`timescale 1ns / 1ps
`default_nettype none

module uart_fifo_pair_rts_cts #(
  parameter int unsigned RX_DEPTH = 128,
  parameter int unsigned TX_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // data_byte[7:0], cts_n[8], zero[15:9]
  input  wire logic [ufp_pkg::S_TDATA_W-1:0]  s_tdata,
  // opcode[2:0]
  input  wire logic [ufp_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // host_byte[7:0], line_byte[15:8], rts_n[16], tx_drain_on[17], rx_level[25:18],
  // tx_level[32:26], fault[34:33], zero[39:35]
  output logic      [ufp_pkg::M_TDATA_W-1:0]  m_tdata,
  // host_byte_valid[0], line_byte_valid[1]
  output logic      [ufp_pkg::M_TUSER_W-1:0]  m_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [ufp_pkg::THR_W-1:0]      cfg_wdata
);
  import ufp_pkg::*;

  ufp_cmd_t cmd;

  ufp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  ufp_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

// ===== design/ufp_ctrl.sv =====
// Controller: transaction sequencing and output register valid.
`timescale 1ns / 1ps
`default_nettype none

module ufp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output ufp_pkg::ufp_cmd_t      cmd
);
  import ufp_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    out_free    = !m_tvalid || m_tready;
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ufp_datapath.sv =====
// Datapath: receive and transmit ring buffers, flow control state and result register.
`timescale 1ns / 1ps
`default_nettype none

module ufp_datapath #(
  parameter int unsigned RX_DEPTH = 128,
  parameter int unsigned TX_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ufp_pkg::ufp_cmd_t               cmd,
  input  wire logic [ufp_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic [ufp_pkg::S_TUSER_W-1:0]   s_tuser,
  input  wire logic                            cfg_we,
  input  wire logic [ufp_pkg::THR_W-1:0]       cfg_wdata,
  output logic      [ufp_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic      [ufp_pkg::M_TUSER_W-1:0]   m_tuser
);
  import ufp_pkg::*;

  localparam int unsigned RXAW = $clog2(RX_DEPTH);
  localparam int unsigned RXCW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TXAW = $clog2(TX_DEPTH);
  localparam int unsigned TXCW = $clog2(TX_DEPTH + 1);

  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0] rx_rd_data;
  logic [BYTE_W-1:0] tx_rd_data;

  logic [RXAW-1:0] rx_wr_ptr;
  logic [RXAW-1:0] rx_rd_ptr;
  logic [RXCW-1:0] rx_count;
  logic [RXCW-1:0] rx_count_next;
  logic [TXAW-1:0] tx_wr_ptr;
  logic [TXAW-1:0] tx_rd_ptr;
  logic [TXCW-1:0] tx_count;
  logic [TXCW-1:0] tx_count_next;
  logic            drain_enable;
  logic            drain_enable_next;
  logic [THR_W-1:0] rts_threshold;

  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] din;
  logic              cts_n_q;

  logic rx_push, rx_pop, tx_push, tx_pop;
  logic rx_full, rx_empty, tx_full, tx_empty;
  fault_t fault;
  logic [BYTE_W-1:0]     host_byte;
  logic [BYTE_W-1:0]     line_byte;
  logic                  rts_n;
  logic [RX_LEVEL_W-1:0] rx_level;
  logic [TX_LEVEL_W-1:0] tx_level;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= s_tuser;
      din     <= s_tdata[BYTE_W-1:0];
      cts_n_q <= s_tdata[BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && rx_push) begin
      rx_mem[rx_wr_ptr] <= din;
    end
    rx_rd_data <= rx_mem[rx_rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && tx_push) begin
      tx_mem[tx_wr_ptr] <= din;
    end
    tx_rd_data <= tx_mem[tx_rd_ptr];
  end

  always_comb begin
    rx_full           = rx_count == RXCW'(RX_DEPTH);
    rx_empty          = rx_count == '0;
    tx_full           = tx_count == TXCW'(TX_DEPTH);
    tx_empty          = tx_count == '0;
    rx_push           = 1'b0;
    rx_pop            = 1'b0;
    tx_push           = 1'b0;
    tx_pop            = 1'b0;
    fault             = FAULT_NONE;
    drain_enable_next = drain_enable;
    case (opcode_t'(op))
      OP_LINK_RX: begin
        if (rx_full) begin
          fault = FAULT_RX_OVERFLOW;
        end else begin
          rx_push = 1'b1;
        end
      end
      OP_HOST_READ: begin
        if (rx_empty) begin
          fault = FAULT_RX_EMPTY;
        end else begin
          rx_pop = 1'b1;
        end
      end
      OP_HOST_WRITE: begin
        if (tx_full) begin
          fault = FAULT_TX_FULL;
        end else begin
          tx_push = 1'b1;
          if (!cts_n_q) begin
            drain_enable_next = 1'b1;
          end
        end
      end
      OP_LINE_READY: begin
        if (drain_enable) begin
          if (tx_empty) begin
            drain_enable_next = 1'b0;
          end else begin
            tx_pop = 1'b1;
          end
        end
      end
      OP_CTS_CHANGE: begin
        if (cts_n_q) begin
          drain_enable_next = 1'b0;
        end else if (!tx_empty) begin
          drain_enable_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    rx_count_next = rx_count;
    if (rx_push) begin
      rx_count_next = rx_count + RXCW'(1);
    end else if (rx_pop) begin
      rx_count_next = rx_count - RXCW'(1);
    end
    tx_count_next = tx_count;
    if (tx_push) begin
      tx_count_next = tx_count + TXCW'(1);
    end else if (tx_pop) begin
      tx_count_next = tx_count - TXCW'(1);
    end

    host_byte = rx_pop ? rx_rd_data : '0;
    line_byte = tx_pop ? tx_rd_data : '0;
    rts_n     = 32'(rx_count_next) >= 32'(rts_threshold);
    rx_level  = RX_LEVEL_W'(32'(rx_count_next));
    tx_level  = TX_LEVEL_W'(32'(tx_count_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wr_ptr    <= '0;
      rx_rd_ptr    <= '0;
      rx_count     <= '0;
      tx_wr_ptr    <= '0;
      tx_rd_ptr    <= '0;
      tx_count     <= '0;
      drain_enable <= 1'b0;
    end else if (cmd.execute) begin
      if (rx_push) begin
        rx_wr_ptr <= (rx_wr_ptr == RXAW'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr + RXAW'(1);
      end
      if (rx_pop) begin
        rx_rd_ptr <= (rx_rd_ptr == RXAW'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr + RXAW'(1);
      end
      if (tx_push) begin
        tx_wr_ptr <= (tx_wr_ptr == TXAW'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr + TXAW'(1);
      end
      if (tx_pop) begin
        tx_rd_ptr <= (tx_rd_ptr == TXAW'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr + TXAW'(1);
      end
      rx_count     <= rx_count_next;
      tx_count     <= tx_count_next;
      drain_enable <= drain_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rts_threshold <= THR_W'(RX_DEPTH - 2);
    end else if (cfg_we) begin
      rts_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      m_tdata <= {{M_TDATA_PAD{1'b0}}, fault, tx_level, rx_level, drain_enable_next, rts_n,
                  line_byte, host_byte};
      m_tuser <= {tx_pop, rx_pop};
    end
  end

  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    32'(rx_count) <= RX_DEPTH)
    else $error("receive count beyond depth");

  a_tx_bound: assert property (@(posedge clk) disable iff (rst)
    32'(tx_count) <= TX_DEPTH)
    else $error("transmit count beyond depth");

  a_rx_push: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && rx_push |=> rx_count == $past(rx_count) + RXCW'(1))
    else $error("receive push did not advance count");

  a_tx_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && tx_pop |=> tx_count == $past(tx_count) - TXCW'(1) && drain_enable)
    else $error("transmit pop lost count or drain enable");

endmodule

`default_nettype wire
